### hw/rtl/sdf_pkg.sv
// sdf_pkg: shared widths, register indexes and transfer structs for the
// sector delta finder; no dependencies
package sdf_pkg;

  localparam int SIZE_W            = 25;
  localparam int ADDR_W            = 32;
  localparam int BYTE_W            = 8;
  localparam int PADDR_W           = 3;
  localparam int PDATA_W           = 32;
  localparam int SIZE_BITS_DEFAULT = 24;

  localparam logic [SIZE_W-1:0] SECTOR_BYTES_RESET = 25'd4096;
  localparam logic [ADDR_W-1:0] IMAGE_BASE_RESET   = '0;

  // register index, taken from paddr bit 2
  typedef enum logic {
    REG_SECTOR_BYTES = 1'b0,
    REG_IMAGE_BASE   = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [SIZE_W-1:0] sector_bytes;
    logic [ADDR_W-1:0] image_base;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] current_byte;
    logic [BYTE_W-1:0] target_byte;
    logic              last;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] sector_address;
    logic [SIZE_W-1:0] sector_length;
  } result_t;

endpackage

### hw/rtl/sdf_cfg_regs.sv
// sdf_cfg_regs: apb-style configuration registers (sector size, base address)
// depends on sdf_pkg
module sdf_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sdf_pkg::PADDR_W-1:0]  paddr,
  input  logic [sdf_pkg::PDATA_W-1:0]  pwdata,
  output logic [sdf_pkg::PDATA_W-1:0]  prdata,
  output sdf_pkg::cfg_t                cfg
);
  import sdf_pkg::*;

  cfg_t       regs;
  reg_index_t index;

  assign index = reg_index_t'(paddr[2]);
  assign cfg   = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.sector_bytes <= SECTOR_BYTES_RESET;
      regs.image_base   <= IMAGE_BASE_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (index)
        REG_SECTOR_BYTES: regs.sector_bytes <= pwdata[SIZE_W-1:0];
        REG_IMAGE_BASE:   regs.image_base   <= pwdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_SECTOR_BYTES: prdata = {{(PDATA_W-SIZE_W){1'b0}}, regs.sector_bytes};
      REG_IMAGE_BASE:   prdata = regs.image_base;
      default:          prdata = '0;
    endcase
  end

endmodule

### hw/rtl/sdf_sector_track.sv
// sdf_sector_track: open-sector state and the single-pass close decision
// depends on sdf_pkg
module sdf_sector_track #(
  parameter int SIZE_BITS = sdf_pkg::SIZE_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  sdf_pkg::item_t   item,
  input  sdf_pkg::cfg_t    cfg,
  output logic             emit,
  output sdf_pkg::result_t result
);
  import sdf_pkg::*;

  localparam int CMP_W = (SIZE_BITS + 1 > SIZE_W) ? SIZE_BITS + 1 : SIZE_W;
  localparam logic [CMP_W-1:0] CAP = {{(CMP_W-1){1'b0}}, 1'b1} << SIZE_BITS;

  logic [SIZE_W-1:0] fill_count;
  logic [SIZE_W-1:0] fill_count_next;
  logic [ADDR_W-1:0] sector_offset;
  logic [ADDR_W-1:0] sector_offset_next;
  logic              mismatch_seen;
  logic              mismatch_seen_next;

  logic [CMP_W-1:0]  size_ext;
  logic [SIZE_W-1:0] size_eff;
  logic [SIZE_W-1:0] fill_inc;
  logic              mismatch;
  logic              closing;
  logic              disabled;

  // sizes above the cap behave as the cap
  assign size_ext = CMP_W'(cfg.sector_bytes);
  assign size_eff = (size_ext > CAP) ? CAP[SIZE_W-1:0] : cfg.sector_bytes;
  assign disabled = (size_eff == '0);

  assign fill_inc = fill_count + SIZE_W'(1);
  assign mismatch = mismatch_seen || (item.current_byte != item.target_byte);
  assign closing  = (fill_inc >= size_eff) || item.last;

  assign emit                  = advance && !disabled && closing && mismatch;
  assign result.sector_address = cfg.image_base + sector_offset;
  assign result.sector_length  = fill_inc;

  always_comb begin
    fill_count_next    = fill_count;
    sector_offset_next = sector_offset;
    mismatch_seen_next = mismatch_seen;
    if (advance) begin
      if (disabled) begin
        fill_count_next    = '0;
        sector_offset_next = '0;
        mismatch_seen_next = 1'b0;
      end else if (closing) begin
        fill_count_next    = '0;
        mismatch_seen_next = 1'b0;
        sector_offset_next = item.last ? '0 : sector_offset + ADDR_W'(fill_inc);
      end else begin
        fill_count_next    = fill_inc;
        mismatch_seen_next = mismatch;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      sector_offset <= '0;
      mismatch_seen <= 1'b0;
    end else begin
      fill_count    <= fill_count_next;
      sector_offset <= sector_offset_next;
      mismatch_seen <= mismatch_seen_next;
    end
  end

endmodule

### hw/rtl/sector_delta_finder_top.sv
// result_valid is registered: a byte pair passes the input register and then the result
// register before its result is shown; one pair per cycle while item_stall is low
// the sector state update and the close decision sit between the input and result
// registers; item_stall rises only while an item is held and a result waits and is stalled
// reset: synchronous; clears sector state and valids, sector byte count to 4096,
// image base to 0
module sector_delta_finder_top #(
  parameter int SIZE_BITS = sdf_pkg::SIZE_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  // byte pair channel
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [sdf_pkg::BYTE_W-1:0]  current_byte,
  input  logic [sdf_pkg::BYTE_W-1:0]  target_byte,
  input  logic                        last,
  // result channel
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [sdf_pkg::ADDR_W-1:0]  sector_address,
  output logic [sdf_pkg::SIZE_W-1:0]  sector_length,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sdf_pkg::PADDR_W-1:0] paddr,
  input  logic [sdf_pkg::PDATA_W-1:0] pwdata,
  output logic [sdf_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import sdf_pkg::*;

  cfg_t    cfg;
  item_t   item_reg;
  logic    item_reg_valid;
  result_t result_reg;
  result_t result_comb;
  logic    out_free;
  logic    advance;
  logic    emit;

  assign pready = 1'b1;

  sdf_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // result register can take a new value when empty or being drained
  assign out_free   = !result_valid || !result_stall;
  assign advance    = item_reg_valid && out_free;
  assign item_stall = item_reg_valid && !out_free;

  // input register: refills in the same cycle it hands off
  always_ff @(posedge clk) begin
    if (rst) begin
      item_reg_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      item_reg_valid <= 1'b1;
    end else if (advance) begin
      item_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_reg.current_byte <= current_byte;
      item_reg.target_byte  <= target_byte;
      item_reg.last         <= last;
    end
  end

  // sector bookkeeping; emit marks an item that closes a differing sector
  sdf_sector_track #(
    .SIZE_BITS (SIZE_BITS)
  ) u_sector_track (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item_reg),
    .cfg     (cfg),
    .emit    (emit),
    .result  (result_comb)
  );

  // result register; items that close nothing just pass through
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result_reg <= result_comb;
    end
  end

  assign sector_address = result_reg.sector_address;
  assign sector_length  = result_reg.sector_length;

`ifndef SYNTHESIS
  // a reported sector always holds at least one byte
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> sector_length != '0)
    else $error("empty sector reported");

  // no sector is ever longer than the capped sector size
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (SIZE_BITS >= SIZE_W) ||
                     (sector_length <= (SIZE_W'(1) << SIZE_BITS)))
    else $error("sector length above maximum");

  // a held result with a pending item must hold back the input side
  assert property (@(posedge clk) disable iff (rst)
    item_reg_valid && result_valid && result_stall |-> item_stall)
    else $error("input taken while result register is blocked");

  // a stalled result must not be overwritten by a new close
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> !emit)
    else $error("result overwritten while stalled");
`endif

endmodule
